// ===== hdl/wkev_pkg.sv =====
// ----------------------------------------------------------------------------
// wkev_pkg
// Shared widths and types for the Wendland kernel evaluation core.
// ----------------------------------------------------------------------------
package wkev_pkg;

    localparam int DistW  = 24;           // Q8.16 distance
    localparam int VecW   = 24;           // Q8.16 vector component
    localparam int NLanes = 6;            // gradient components
    localparam int PreW   = 37;           // gradient prefactor, Q.24
    localparam int NumW   = VecW + PreW;  // dividend |v| * pre
    localparam int QuoW   = 32;           // quotient bits kept
    localparam int DivLat = QuoW + 1;     // overflow check plus one bit per stage

    localparam logic [1:0] RegInvH    = 2'd0;
    localparam logic [1:0] RegWCoeff  = 2'd1;
    localparam logic [1:0] RegDwCoeff = 2'd2;

    // sideband that rides along with the divider lanes
    typedef struct packed {
        logic [NLanes-1:0] neg;
        logic [31:0]       weight;
        logic              outside;
        logic              zero_dist;
    } t_side;

endpackage

// ===== hdl/wkev_div.sv =====
// ----------------------------------------------------------------------------
// wkev_div
// Pipelined restoring divider: one quotient bit per stage, with an
// overflow flag for quotients that do not fit in QuoW bits.
// ----------------------------------------------------------------------------
module wkev_div
    import wkev_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [NumW-1:0] i_num,
    input  logic [DistW-1:0] i_den,
    output logic [QuoW-1:0] o_quo,
    output logic            o_ovf
);

    logic [DistW-1:0] r_rem [DivLat];
    logic [QuoW-1:0]  r_sh  [DivLat];
    logic [DistW-1:0] r_den [DivLat];
    logic             r_ovf [DivLat];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quotient overflows when the high part already reaches the divisor
            r_ovf[0] <= i_num[NumW-1:QuoW] >= (NumW-QuoW)'(i_den);
            r_rem[0] <= i_num[QuoW+DistW-1:QuoW];
            r_sh[0]  <= i_num[QuoW-1:0];
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 1; k < DivLat; k++) begin : g_step
        logic [DistW:0] rem2;
        logic [DistW:0] diff;
        logic           ge;
        assign rem2 = {r_rem[k-1], r_sh[k-1][QuoW-1]};
        assign diff = rem2 - {1'b0, r_den[k-1]};
        assign ge   = rem2 >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DistW-1:0] : rem2[DistW-1:0];
                r_sh[k]  <= {r_sh[k-1][QuoW-2:0], ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_sh[DivLat-1];
    assign o_ovf = r_ovf[DivLat-1];

endmodule

// ===== hdl/wendland_kernel_eval_core.sv =====
// ----------------------------------------------------------------------------
// wendland_kernel_eval_core
// Wendland C2 kernel weight and gradient vectors for one particle pair.
// ----------------------------------------------------------------------------
// One pair beat enters per cycle: eight multiply stages form q, (2-q)^n, the
// weight, the gradient prefactor and its products with the vector magnitudes,
// then a 33-stage divider per gradient component (one quotient bit per stage)
// divides by the distance, and an output register holds the result beat. The
// whole pipeline advances while the output is empty or being taken, so
// throughput is one pair per cycle. Results saturate; q above two zeroes
// everything and sets outside_radius, a zero distance zeroes the gradients and
// sets zero_distance. Configuration writes are taken in every cycle.
module wendland_kernel_eval_core
    import wkev_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // distance, vec_o_x, vec_o_y, vec_o_z, vec_n_x, vec_n_y, vec_n_z (lsb up)
    input  logic [167:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // weight, grad_o_x, grad_o_y, grad_o_z, grad_n_x, grad_n_y, grad_n_z (lsb up)
    output logic [223:0] m_axis_tdata,
    // outside_radius, zero_distance (lsb up)
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int NStg = 8 + DivLat + 1;

    logic [23:0] r_inv_h;
    logic [31:0] r_w_coeff;
    logic [31:0] r_dw_coeff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_h    <= 24'd65536;
            r_w_coeff  <= 32'd584102;
            r_dw_coeff <= 32'd584102;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegInvH:    r_inv_h    <= i_cfg_data[23:0];
                RegWCoeff:  r_w_coeff  <= i_cfg_data;
                RegDwCoeff: r_dw_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic            en;
    logic [NStg-1:0] r_vld;

    assign en            = !r_vld[NStg-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[NStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NStg-2:0], s_axis_tvalid};
        end
    end

    // distance rides along stages 1..8, the vectors along stages 1..7
    logic [DistW-1:0]                 r_dist [1:8];
    logic [NLanes-1:0][VecW-1:0]      r_vec  [1:7];
    logic [NLanes-1:0][VecW-1:0]      in_vec;

    assign in_vec = s_axis_tdata[167:24];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist[1] <= s_axis_tdata[23:0];
            r_vec[1]  <= in_vec;
            for (int s = 2; s <= 8; s++) r_dist[s] <= r_dist[s-1];
            for (int s = 2; s <= 7; s++) r_vec[s] <= r_vec[s-1];
        end
    end

    // stage products
    logic [47:0] m1;
    logic [51:0] m3;
    logic [52:0] m4a;
    logic [53:0] m4b;
    logic [55:0] m5a;
    logic [53:0] m5b;
    logic [62:0] m6a;
    logic [32:0] m6b;
    logic [64:0] m7;

    logic [47:0] r1_prod;
    logic [25:0] r2_q, r2_d;
    logic        r_out [2:8];
    logic [25:0] r3_q, r3_d;
    logic [26:0] r3_d2, r3_lin;
    logic [25:0] r4_q;
    logic [27:0] r4_d3;
    logic [28:0] r4_d4;
    logic [26:0] r4_lin;
    logic [30:0] r5_wb;
    logic [28:0] r5_qd3;
    logic [31:0] r6_w, r7_w, r8_w;
    logic [32:0] r6_qd10;
    logic [PreW-1:0] r7_pre;

    assign m1  = 48'(r_dist[1] * 0) | (48'(s_axis_tdata[23:0]) * 48'(r_inv_h));
    assign m3  = 52'(r2_d) * 52'(r2_d);
    assign m4a = 53'(r3_d2) * 53'(r3_d);
    assign m4b = 54'(r3_d2) * 54'(r3_d2);
    assign m5a = 56'(r4_d4) * 56'(r4_lin);
    assign m5b = 54'(r4_q) * 54'(r4_d3);
    assign m6a = 63'(r5_wb) * 63'(r_w_coeff);
    assign m6b = 33'(r5_qd3) * 33'd10;
    assign m7  = 65'(r6_qd10) * 65'(r_dw_coeff);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= m1;
            // q above two is compared at full precision
            r_out[2] <= r1_prod > 48'h2_0000_0000;
            r2_q     <= r1_prod[33:8];
            r2_d     <= 26'h200_0000 - r1_prod[33:8];
            r_out[3] <= r_out[2];
            r3_q     <= r2_q;
            r3_d     <= r2_d;
            r3_d2    <= m3[50:24];
            r3_lin   <= {r2_q, 1'b0} + 27'h100_0000;
            r_out[4] <= r_out[3];
            r4_q     <= r3_q;
            r4_lin   <= r3_lin;
            r4_d3    <= m4a[51:24];
            r4_d4    <= m4b[52:24];
            r_out[5] <= r_out[4];
            r5_wb    <= m5a[54:24];
            r5_qd3   <= m5b[52:24];
            r_out[6] <= r_out[5];
            r6_w     <= (|m6a[62:56]) ? 32'hFFFF_FFFF : m6a[55:24];
            r6_qd10  <= m6b;
            r_out[7] <= r_out[6];
            r7_w     <= r6_w;
            r7_pre   <= m7[60:24];
            r_out[8] <= r_out[7];
            r8_w     <= r7_w;
        end
    end

    // stage 8: magnitudes times prefactor
    logic [NumW-1:0]   r8_num [NLanes];
    logic [NLanes-1:0] r8_neg;

    for (genvar k = 0; k < NLanes; k++) begin : g_num
        logic [VecW-1:0] mag;
        assign mag = r_vec[7][k][VecW-1] ? VecW'(-r_vec[7][k]) : r_vec[7][k];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r8_num[k] <= NumW'(mag) * NumW'(r7_pre);
                r8_neg[k] <= r_vec[7][k][VecW-1];
            end
        end
    end

    // divider lanes and their sideband
    logic [QuoW-1:0]   quo [NLanes];
    logic [NLanes-1:0] ovf;
    t_side             r_sd [DivLat];

    for (genvar k = 0; k < NLanes; k++) begin : g_div
        wkev_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r8_num[k]),
            .i_den (r_dist[8]),
            .o_quo (quo[k]),
            .o_ovf (ovf[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0].neg       <= r8_neg;
            r_sd[0].weight    <= r8_w;
            r_sd[0].outside   <= r_out[8];
            r_sd[0].zero_dist <= (r_dist[8] == '0) && !r_out[8];
            for (int s = 1; s < DivLat; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    // sign, saturate and zero the special cases
    logic [NLanes-1:0][31:0] grad;
    t_side                   sd;

    assign sd = r_sd[DivLat-1];

    always_comb begin
        for (int k = 0; k < NLanes; k++) begin
            if (sd.outside || sd.zero_dist) begin
                grad[k] = '0;
            end else if (sd.neg[k]) begin
                if (ovf[k] || quo[k] > 32'h8000_0000) grad[k] = 32'h8000_0000;
                else                                  grad[k] = 32'd0 - quo[k];
            end else begin
                if (ovf[k] || quo[k][31]) grad[k] = 32'h7FFF_FFFF;
                else                      grad[k] = quo[k];
            end
        end
    end

    logic [223:0] r_o_data;
    logic [1:0]   r_o_user;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= {grad, sd.outside ? 32'd0 : sd.weight};
            r_o_user <= {sd.zero_dist, sd.outside};
        end
    end

    assign m_axis_tdata = r_o_data;
    assign m_axis_tuser = r_o_user;

endmodule

// ===== hdl/wkev_checker.sv =====
// ----------------------------------------------------------------------------
// wkev_checker
// Port-level checks of the kernel core, bound to the top level.
// ----------------------------------------------------------------------------
module wkev_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic [223:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed under stall");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("outside radius beat carries data or zero distance flag");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[223:32] == '0)
        else $error("zero distance beat carries gradients");

endmodule

bind wendland_kernel_eval_core wkev_checker u_wkev_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

// ===== bench/wendland_kernel_eval_core_tb.sv =====
// ----------------------------------------------------------------------------
// wendland_kernel_eval_core_tb
// Streams particle pairs through the kernel core and checks weight, gradients
// and flags of every result beat against a fixed-point prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [31:0] grad_n_z;
    logic [31:0] grad_n_y;
    logic [31:0] grad_n_x;
    logic [31:0] grad_o_z;
    logic [31:0] grad_o_y;
    logic [31:0] grad_o_x;
    logic [31:0] weight;
    logic        zero_distance;
    logic        outside_radius;
} t_kernel_res;

class kernel_scoreboard;
    logic [23:0] inv_h;
    logic [31:0] w_coeff;
    logic [31:0] dw_coeff;
    t_kernel_res pending[$];
    int          errors;
    int          checked;

    function new();
        inv_h    = 24'd65536;
        w_coeff  = 32'd584102;
        dw_coeff = 32'd584102;
        errors   = 0;
        checked  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        if (idx == wkev_pkg::RegInvH) inv_h = val[23:0];
        else if (idx == wkev_pkg::RegWCoeff) w_coeff = val;
        else if (idx == wkev_pkg::RegDwCoeff) dw_coeff = val;
    endfunction

    function logic [31:0] scale_grad(logic [23:0] raw, logic [63:0] pre, logic [63:0] rdist);
        logic [23:0] mag24;
        logic [63:0] mag;
        logic [63:0] quo;
        mag24 = raw[23] ? (24'd0 - raw) : raw;
        mag = 64'(mag24);
        quo = (mag * pre) / rdist;
        if (raw[23]) begin
            if (quo > 64'h8000_0000) quo = 64'h8000_0000;
            return 32'(-quo);
        end
        if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
        return quo[31:0];
    endfunction

    function void note_pair(logic [167:0] beat);
        t_kernel_res r;
        logic [63:0] rdist, prod, q, d, d2, d3, d4, wb, w, qd3, pre;
        logic [127:0] wide;
        logic [23:0] comp[6];
        r = '0;
        rdist = 64'(beat[23:0]);
        for (int j = 0; j < 6; j++) comp[j] = beat[24*(j+1) +: 24];
        prod = rdist * 64'(inv_h);
        if (prod > (64'd2 << 32)) begin
            r.outside_radius = 1'b1;
        end else begin
            q   = prod >> 8;
            d   = (64'd2 << 24) - q;
            d2  = (d * d) >> 24;
            d3  = (d2 * d) >> 24;
            d4  = (d2 * d2) >> 24;
            wb  = (d4 * (2 * q + (64'd1 << 24))) >> 24;
            w   = (wb * 64'(w_coeff)) >> 24;
            qd3 = (q * d3) >> 24;
            wide = 128'(qd3) * 128'd10 * 128'(dw_coeff);
            pre = 64'(wide >> 24);
            r.weight = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
            if (rdist == 0) begin
                r.zero_distance = 1'b1;
            end else begin
                r.grad_o_x = scale_grad(comp[0], pre, rdist);
                r.grad_o_y = scale_grad(comp[1], pre, rdist);
                r.grad_o_z = scale_grad(comp[2], pre, rdist);
                r.grad_n_x = scale_grad(comp[3], pre, rdist);
                r.grad_n_y = scale_grad(comp[4], pre, rdist);
                r.grad_n_z = scale_grad(comp[5], pre, rdist);
            end
        end
        pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %h expected %h (beat %0d)", what, got, exp, checked);
        errors++;
    endtask

    task check_result(logic [223:0] data, logic [1:0] user);
        t_kernel_res e;
        if (pending.size() == 0) begin
            report("unexpected beat", 32'd1, 32'd0);
            return;
        end
        e = pending.pop_front();
        if (data[31:0] != e.weight) report("weight", data[31:0], e.weight);
        if (data[63:32] != e.grad_o_x) report("grad_o_x", data[63:32], e.grad_o_x);
        if (data[95:64] != e.grad_o_y) report("grad_o_y", data[95:64], e.grad_o_y);
        if (data[127:96] != e.grad_o_z) report("grad_o_z", data[127:96], e.grad_o_z);
        if (data[159:128] != e.grad_n_x) report("grad_n_x", data[159:128], e.grad_n_x);
        if (data[191:160] != e.grad_n_y) report("grad_n_y", data[191:160], e.grad_n_y);
        if (data[223:192] != e.grad_n_z) report("grad_n_z", data[223:192], e.grad_n_z);
        if (user[0] != e.outside_radius) report("outside_radius", user[0], e.outside_radius);
        if (user[1] != e.zero_distance) report("zero_distance", user[1], e.zero_distance);
        checked++;
    endtask
endclass

module wendland_kernel_eval_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wkev_pkg::*;

    localparam int Latency = 42;
    localparam int CycleLimit = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    kernel_scoreboard sb;
    int cycles;
    int sent;
    bit drain_hold;

    wendland_kernel_eval_core uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial sb = new();

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("[wendland_kernel_eval_core] ERROR");
            $finish;
        end
    end

    // sample result beats at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // sink backpressure, changed at the falling edge
    initial begin
        int g;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (drain_hold) begin
                m_axis_tready <= 1'b1;
            end else begin
                g = pick_gap();
                if (g == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(logic [167:0] beat);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tdata  <= beat;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pair(beat);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (Latency + 4) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand_vec();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_dist(logic [23:0] ih);
        logic [63:0] edge2;
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(1, 16));
            3: return 24'($urandom);
            default: begin
                // mostly inside the support radius
                if (ih == 0) return 24'($urandom);
                edge2 = (64'd2 << 32) / ih;
                if (edge2 > 64'hFFFFFF) edge2 = 64'hFFFFFF;
                return 24'($urandom_range(0, 32'(edge2) + 2));
            end
        endcase
    endfunction

    function automatic logic [167:0] make_pair(logic [23:0] pair_dist);
        logic [167:0] b;
        b[23:0] = pair_dist;
        for (int j = 1; j < 7; j++) b[24*j +: 24] = rand_vec();
        return b;
    endfunction

    initial begin
        logic [23:0] ih_set[5];
        logic [31:0] wc_set[5];
        logic [31:0] dc_set[5];
        cycles = 0;
        sent = 0;
        drain_hold = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = RegInvH;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset settings, field extremes and special cases
        send_pair(make_pair(24'd0));                  // zero distance
        send_pair({{6{24'h7FFFFF}}, 24'd1});
        send_pair({{6{24'h800000}}, 24'd1});
        send_pair({{6{24'h7FFFFF}}, 24'h020000});     // q equal to two
        send_pair({{6{24'h800000}}, 24'h020001});     // just outside
        send_pair({{6{24'h000000}}, 24'hFFFFFF});
        send_pair({{3{24'h000001}}, {3{24'hFFFFFF}}, 24'h010000});
        send_pair({{3{24'h555555}}, {3{24'hAAAAAA}}, 24'h008000});
        wait_drained();
        write_reg(RegInvH, 24'hFFFFFF);
        write_reg(RegWCoeff, 32'hFFFFFFFF);
        write_reg(RegDwCoeff, 32'hFFFFFFFF);
        write_reg(2'd3, 32'h12345678);                // unused index, ignored
        send_pair({{6{24'h7FFFFF}}, 24'd1});
        send_pair({{6{24'h800000}}, 24'd2});
        send_pair(make_pair(24'd0));
        send_pair(make_pair(24'd3));
        wait_drained();
        write_reg(RegInvH, 24'd0);
        write_reg(RegWCoeff, 32'd0);
        write_reg(RegDwCoeff, 32'd0);
        send_pair({{6{24'h7FFFFF}}, 24'hFFFFFF});
        send_pair(make_pair(24'd0));
        wait_drained();

        ih_set = '{24'd65536, 24'hFFFFFF, 24'd0, 24'd256, 24'd0};
        wc_set = '{32'd584102, 32'hFFFFFFFF, 32'd0, 32'h01000000, 32'd0};
        dc_set = '{32'd584102, 32'hFFFFFFFF, 32'd0, 32'h10000000, 32'd0};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 5 && ph != 4) begin
                write_reg(RegInvH, ih_set[ph]);
                write_reg(RegWCoeff, wc_set[ph]);
                write_reg(RegDwCoeff, dc_set[ph]);
            end else begin
                write_reg(RegInvH, 24'($urandom));
                write_reg(RegWCoeff, $urandom);
                write_reg(RegDwCoeff, $urandom);
            end
            for (int n = 0; n < 150; n++) begin
                send_pair(make_pair(rand_dist(sb.inv_h)));
                // hold the source until the pipe has fully drained
                if (ph == 2 && n == 70) begin
                    s_axis_tvalid <= 1'b0;
                    while (sb.pending.size() != 0) @(negedge i_clk);
                end
            end
            wait_drained();
        end

        drain_hold = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (Latency + 8) @(negedge i_clk);
        $display("sent %0d pairs over several register settings, %0d results checked",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[wendland_kernel_eval_core] OK");
        else
            $display("[wendland_kernel_eval_core] ERROR");
        $finish;
    end
endmodule
